[sv/spsg_pkg.sv]
package spsg_pkg;

  // Table and level sizing.
  localparam int MAX_SEGMENTS = 64;
  localparam int LEVEL_BITS   = 24;
  localparam int SEG_IDX_BITS = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  // Field widths of the stream items.
  localparam int MODE_BITS    = 2;
  localparam int TIME_BITS    = 32;
  localparam int INDEX_BITS   = 6;
  localparam int SECONDS_BITS = 16;
  localparam int TARGET_BITS  = 24;
  localparam int KIND_BITS    = 2;
  localparam int COUNT_BITS   = 7;
  localparam int PERIOD_BITS  = 16;
  localparam int SETPT_BITS   = 24;

  // Stream packing.
  localparam int IN_DATA_BITS  = 80;
  localparam int OUT_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 16;

  // Duration in ms fits in this many bits (65535 s * 1000).
  localparam int MS_PER_SECOND = 1000;
  localparam int MS_MULT_BITS  = 10;
  localparam int DUR_BITS      = 26;
  localparam int PROD_BITS     = LEVEL_BITS + DUR_BITS;
  localparam int DIV_CNT_BITS  = $clog2(LEVEL_BITS);

  // Wide compare widths for index and count checks.
  localparam int CMP_BITS = 9;
  localparam logic [CMP_BITS-1:0] MAX_SEG_CMP = CMP_BITS'(MAX_SEGMENTS);

  // Table word: seconds in the low bits, then target, then kind.
  localparam int RAM_BITS = SECONDS_BITS + LEVEL_BITS + KIND_BITS;

  localparam logic [PERIOD_BITS-1:0] RESET_PERIOD_MS = PERIOD_BITS'(500);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEGMENT_COUNT = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_UPDATE_PERIOD = CFG_IDX_BITS'(1);

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_STEP = 2'd0,
    KIND_HOLD = 2'd1,
    KIND_RAMP = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_EVAL,
    ST_WAIT,
    ST_APPLY,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_COMMIT,
    ST_EMIT,
    ST_EMIT_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic ram_wr;
    logic start;
    logic restamp;
    logic rd_en;
    logic rd_next;
    logic advance;
    logic set_level;
    logic mul;
    logic div_load;
    logic div_step;
    logic commit;
    logic out_load;
    logic out_done;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [KIND_BITS-1:0] kind;
    logic tick_due;
    logic in_range;
    logic expired;
    logic last_seg;
    logic dur_zero;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

[sv/spsg_ram.sv]
module spsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/spsg_ctrl.sv]
module spsg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  spsg_pkg::status_t status,
  output spsg_pkg::cmd_t    cmd
);

  import spsg_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_next = ST_IDLE;
        unique case (status.mode)
          MODE_LOAD: begin
            cmd.ram_wr = 1'b1;
          end
          MODE_START: begin
            cmd.start = 1'b1;
          end
          MODE_TICK: begin
            if (status.tick_due) begin
              cmd.restamp = 1'b1;
              if (status.in_range) begin
                cmd.rd_en  = 1'b1;
                state_next = ST_READ;
              end
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        // Expiry check on the current segment; advance by one at most.
        cmd.advance = status.expired;
        if (status.expired && status.last_seg) begin
          state_next = ST_EMIT_DONE;
        end else if (status.expired) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_next  = ST_WAIT;
        end else begin
          state_next = ST_APPLY;
        end
      end
      ST_WAIT: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (status.kind == KIND_RAMP && !status.dur_zero) begin
          state_next = ST_MUL;
        end else begin
          cmd.set_level = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_EMIT_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_done = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/spsg_dpath.sv]
module spsg_dpath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  spsg_pkg::cmd_t                        cmd,
  output spsg_pkg::status_t                     status,
  input  logic [spsg_pkg::IN_DATA_BITS-1:0]     s_tdata,
  input  logic [spsg_pkg::MODE_BITS-1:0]        s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [spsg_pkg::OUT_DATA_BITS-1:0]    m_tdata,
  output logic                                  m_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [spsg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [spsg_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  import spsg_pkg::*;

  // Latched input item.
  logic [MODE_BITS-1:0]    item_mode;
  logic [TIME_BITS-1:0]    item_now;
  logic [INDEX_BITS-1:0]   item_idx;
  logic [SECONDS_BITS-1:0] item_sec;
  logic [TARGET_BITS-1:0]  item_target;
  logic [KIND_BITS-1:0]    item_kind;

  // Configuration.
  logic [COUNT_BITS-1:0]  seg_count;
  logic [PERIOD_BITS-1:0] update_period;

  // Generator state.
  logic                  running;
  logic [COUNT_BITS-1:0] cur_seg;
  logic [TIME_BITS-1:0]  seg_start_time;
  logic [TIME_BITS-1:0]  last_update;
  logic [LEVEL_BITS-1:0] seg_start_level;
  logic [LEVEL_BITS-1:0] present;
  logic [DUR_BITS-1:0]   elapsed;

  // Ramp arithmetic.
  logic                    ramp_neg;
  logic [PROD_BITS-1:0]    prod;
  logic [DUR_BITS-1:0]     div_dur;
  logic [DUR_BITS-1:0]     rem;
  logic [LEVEL_BITS-1:0]   dividend_lo;
  logic [LEVEL_BITS-1:0]   quo;
  logic [DIV_CNT_BITS-1:0] div_cnt;

  // Table read side.
  logic                    ram_wr_en;
  logic [SEG_IDX_BITS-1:0] ram_wr_addr;
  logic [RAM_BITS-1:0]     ram_wr_data;
  logic [SEG_IDX_BITS-1:0] ram_rd_addr;
  logic [RAM_BITS-1:0]     ram_rd_data;
  logic [SECONDS_BITS-1:0] rd_sec;
  logic [LEVEL_BITS-1:0]   rd_target;
  logic [KIND_BITS-1:0]    rd_kind;
  logic [DUR_BITS-1:0]     rd_dur;

  // Derived values.
  logic [CMP_BITS-1:0]   count_eff;
  logic [CMP_BITS-1:0]   cur_cmp;
  logic [TIME_BITS-1:0]  since_update;
  logic [TIME_BITS-1:0]  el_full;
  logic [LEVEL_BITS-1:0] diff_mag;
  logic [DUR_BITS:0]     div_trial;
  logic                  div_ge;

  assign cfg_ready = 1'b1;

  // Segment table.
  assign ram_wr_en   = cmd.ram_wr && (CMP_BITS'(item_idx) < MAX_SEG_CMP);
  assign ram_wr_addr = SEG_IDX_BITS'(item_idx);
  assign ram_wr_data = {item_kind, LEVEL_BITS'(item_target), item_sec};
  assign ram_rd_addr = cmd.rd_next ? SEG_IDX_BITS'(cur_seg + COUNT_BITS'(1))
                                   : SEG_IDX_BITS'(cur_seg);

  spsg_ram #(
    .WIDTH (RAM_BITS),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_sec    = ram_rd_data[SECONDS_BITS-1:0];
  assign rd_target = ram_rd_data[SECONDS_BITS +: LEVEL_BITS];
  assign rd_kind   = ram_rd_data[RAM_BITS-1 -: KIND_BITS];
  assign rd_dur    = DUR_BITS'(rd_sec * MS_MULT_BITS'(MS_PER_SECOND));

  // Comparisons reported to the controller.
  assign count_eff    = (CMP_BITS'(seg_count) > MAX_SEG_CMP) ? MAX_SEG_CMP
                                                             : CMP_BITS'(seg_count);
  assign cur_cmp      = CMP_BITS'(cur_seg);
  assign since_update = item_now - last_update;
  assign el_full      = item_now - seg_start_time;
  assign diff_mag     = ramp_neg ? (seg_start_level - rd_target)
                                 : (rd_target - seg_start_level);
  assign div_trial    = {rem, dividend_lo[LEVEL_BITS-1]};
  assign div_ge       = div_trial >= {1'b0, div_dur};

  always_comb begin
    status          = '0;
    status.mode     = item_mode;
    status.kind     = rd_kind;
    status.tick_due = running && (since_update >= TIME_BITS'(update_period));
    status.in_range = cur_cmp < count_eff;
    status.expired  = el_full >= TIME_BITS'(rd_dur);
    status.last_seg = (cur_cmp + CMP_BITS'(1)) >= count_eff;
    status.dur_zero = (rd_dur == '0);
    status.div_last = (div_cnt == DIV_CNT_BITS'(LEVEL_BITS - 1));
    status.out_free = !m_tvalid || m_tready;
  end

  // Input item capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_mode   <= s_tuser;
      item_now    <= s_tdata[31:0];
      item_idx    <= s_tdata[37:32];
      item_sec    <= s_tdata[53:38];
      item_target <= s_tdata[77:54];
      item_kind   <= s_tdata[79:78];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count     <= '0;
      update_period <= RESET_PERIOD_MS;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SEGMENT_COUNT) begin
        seg_count <= COUNT_BITS'(cfg_data);
      end else if (cfg_index == CFG_UPDATE_PERIOD) begin
        update_period <= cfg_data;
      end
    end
  end

  // Generator state: start, restamp, segment advance and level updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      cur_seg         <= '0;
      seg_start_time  <= '0;
      last_update     <= '0;
      seg_start_level <= '0;
      present         <= '0;
    end else begin
      if (cmd.start) begin
        running         <= 1'b1;
        cur_seg         <= '0;
        seg_start_time  <= item_now;
        last_update     <= item_now;
        seg_start_level <= '0;
        present         <= '0;
      end
      if (cmd.restamp) begin
        last_update <= item_now;
      end
      if (cmd.advance) begin
        cur_seg         <= cur_seg + COUNT_BITS'(1);
        seg_start_time  <= item_now;
        seg_start_level <= present;
        if (status.last_seg) begin
          running <= 1'b0;
        end
      end
      if (cmd.set_level) begin
        if (rd_kind == KIND_STEP) begin
          present <= rd_target;
        end else if (rd_kind == KIND_HOLD) begin
          present <= seg_start_level;
        end
      end
      if (cmd.commit) begin
        present <= ramp_neg ? (seg_start_level - quo) : (seg_start_level + quo);
      end
    end
  end

  // Elapsed time within the segment. Once the segment has advanced, the start
  // time equals the item time, so the tracked value falls to zero.
  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      elapsed <= '0;
    end else begin
      elapsed <= DUR_BITS'(el_full);
    end
  end

  // Magnitude product, then a restoring division one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PROD_BITS'(diff_mag * elapsed);
    end
    if (cmd.div_load) begin
      div_dur     <= rd_dur;
      rem         <= prod[PROD_BITS-1 -: DUR_BITS];
      dividend_lo <= prod[LEVEL_BITS-1:0];
      quo         <= '0;
      div_cnt     <= '0;
    end else if (cmd.div_step) begin
      rem         <= div_ge ? DUR_BITS'(div_trial - {1'b0, div_dur})
                            : div_trial[DUR_BITS-1:0];
      dividend_lo <= {dividend_lo[LEVEL_BITS-2:0], 1'b0};
      quo         <= {quo[LEVEL_BITS-2:0], div_ge};
      div_cnt     <= div_cnt + DIV_CNT_BITS'(1);
    end
  end

  // Ramp direction, held while the product is formed.
  always_ff @(posedge clk) begin
    if (cmd.set_level || cmd.mul) begin
      ramp_neg <= ramp_neg;
    end else begin
      ramp_neg <= rd_target < seg_start_level;
    end
  end

  // Output register; a held result leaves only by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= cmd.out_done;
      m_tdata <= {1'b0, cur_seg,
                  cmd.out_done ? SETPT_BITS'(0) : SETPT_BITS'(present)};
    end
  end

endmodule

[sv/segment_profile_setpoint_generator.sv]
// A load or start is done in the dispatch state; a tick with a step, hold or finish result
// reads the table and checks expiry before the result is loaded; a ramp tick also multiplies and divides.
// One item at a time: the next transfer is taken only once the item is done, so a
// result stall or the ramp divider holds off the next item.
// Reset (synchronous, active high) idles the generator, clears the output valid and
// loads segment_count 0 and update_period_ms 500; the segment table is not cleared.
module segment_profile_setpoint_generator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // now_ms[31:0], entry_index[37:32], entry_seconds[53:38], entry_target[77:54],
  // entry_kind[79:78]
  input  logic [spsg_pkg::IN_DATA_BITS-1:0]     s_tdata,
  // mode[1:0]
  input  logic [spsg_pkg::MODE_BITS-1:0]        s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // drive_setpoint[23:0], active_segment[30:24], zero[31]
  output logic [spsg_pkg::OUT_DATA_BITS-1:0]    m_tdata,
  // profile_done[0]
  output logic                                  m_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [spsg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [spsg_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  import spsg_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  spsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Table, state registers, ramp arithmetic and output register.
  spsg_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[sv/spsg_checker.sv]
module spsg_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tvalid,
  input logic                                  s_tready,
  input logic [spsg_pkg::IN_DATA_BITS-1:0]     s_tdata,
  input logic [spsg_pkg::MODE_BITS-1:0]        s_tuser,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [spsg_pkg::OUT_DATA_BITS-1:0]    m_tdata,
  input logic                                  m_tuser,
  input logic                                  cfg_valid,
  input logic                                  cfg_ready,
  input logic [spsg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input logic [spsg_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  import spsg_pkg::*;

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A finished result carries no setpoint.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[23:0] == 24'd0)
    else $error("finished result with nonzero setpoint");

  // The reported segment never passes the table size.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[30:24] <= 7'(MAX_SEGMENTS) && !m_tdata[31])
    else $error("active segment out of range");

  // Items are worked one at a time: no transfer right after a transfer.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

  // Reset empties the output register.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind segment_profile_setpoint_generator spsg_checker u_spsg_checker (.*);
